[rtl/zorht_pkg.sv]
`default_nettype none

package zorht_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 9;
  localparam int SLOT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FIN
  } state_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic add_en;
    logic del_en;
    logic hit_load;
    logic hit_shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/z_ordered_rectangle_hit_table.sv]
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_cmd, in_pos_x, in_pos_y,
//                                            in_rect_width, in_rect_height
// out      output     out_valid / out_stall  out_status, out_control_id, out_hit_slot
//
// add, delete and unused commands finish in the accept cycle; the result is
// registered and shows on the next cycle.
// select runs in steps: the accept latches the point, ST_LOAD has every cell
// test it, then in ST_SCAN the hit bits shift up the chain one slot a cycle
// from the top slot down until the first hit, then ST_FIN posts when free.
// a delete moves every later entry down one slot along the chain in the accept cycle.
// reset is synchronous and clears the count, the selection and the sequencer;
// entry storage is not cleared. out_stall holds the result register, and a
// new item is taken in ST_IDLE while the result register is free or being taken.

module z_ordered_rectangle_hit_table #(
  parameter int MAX_ENTRIES = 256,
  parameter int COORD_BITS  = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [zorht_pkg::CMD_W-1:0]       in_cmd,
  input  wire  [COORD_BITS-1:0]             in_pos_x,
  input  wire  [COORD_BITS-1:0]             in_pos_y,
  input  wire  [COORD_BITS-1:0]             in_rect_width,
  input  wire  [COORD_BITS-1:0]             in_rect_height,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [zorht_pkg::STATUS_W-1:0]    out_status,
  output logic [zorht_pkg::ID_W-1:0]        out_control_id,
  output logic [zorht_pkg::SLOT_W-1:0]      out_hit_slot
);

  import zorht_pkg::*;

  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int IDXW = $clog2(MAX_ENTRIES);

  state_t                state_r, state_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic                  sel_valid_r, sel_valid_nxt;
  logic [IDXW-1:0]       sel_slot_r, sel_slot_nxt;
  logic [IDXW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;

  cell_ctl_t             ctl;
  logic                  in_acc;
  logic                  out_free;
  logic [CNTW:0]         new_id;
  logic                  top_hit;

  logic [COORD_BITS-1:0] left_q [MAX_ENTRIES];
  logic [COORD_BITS-1:0] top_q  [MAX_ENTRIES];
  logic [COORD_BITS-1:0] w_q    [MAX_ENTRIES];
  logic [COORD_BITS-1:0] h_q    [MAX_ENTRIES];
  logic                  hit_q  [MAX_ENTRIES];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign new_id   = {1'b0, count_r} + {{CNTW{1'b0}}, 1'b1};
  assign top_hit  = hit_q[MAX_ENTRIES-1];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [COORD_BITS-1:0] nb_left, nb_top, nb_w, nb_h;
    logic                  hit_in;

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nb_left = left_q[i];
      assign nb_top  = top_q[i];
      assign nb_w    = w_q[i];
      assign nb_h    = h_q[i];
    end else begin : g_mid
      assign nb_left = left_q[i+1];
      assign nb_top  = top_q[i+1];
      assign nb_w    = w_q[i+1];
      assign nb_h    = h_q[i+1];
    end

    if (i == 0) begin : g_first
      assign hit_in = 1'b0;
    end else begin : g_rest
      assign hit_in = hit_q[i-1];
    end

    zorht_cell #(
      .COORD_BITS (COORD_BITS),
      .CNTW       (CNTW),
      .IDXW       (IDXW),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .count    (count_r),
      .sel_slot (sel_slot_r),
      .new_left (in_pos_x),
      .new_top  (in_pos_y),
      .new_w    (in_rect_width),
      .new_h    (in_rect_height),
      .pt_x     (px_r),
      .pt_y     (py_r),
      .nb_left  (nb_left),
      .nb_top   (nb_top),
      .nb_w     (nb_w),
      .nb_h     (nb_h),
      .hit_in   (hit_in),
      .left     (left_q[i]),
      .top      (top_q[i]),
      .w        (w_q[i]),
      .h        (h_q[i]),
      .hit_out  (hit_q[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sel_valid_nxt  = sel_valid_r;
    sel_slot_nxt   = sel_slot_r;
    scan_idx_nxt   = scan_idx_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_slot_nxt   = out_slot_r;
    ctl            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_id_nxt   = '0;
          out_slot_nxt = '0;
          unique case (in_cmd)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (count_r < CNTW'(MAX_ENTRIES)) begin
                ctl.add_en     = 1'b1;
                count_nxt      = new_id[CNTW-1:0];
                out_status_nxt = STAT_OK;
                out_id_nxt     = ID_W'(new_id);
              end else begin
                out_status_nxt = STAT_INVALID;
              end
            end
            CMD_SELECT: begin
              px_nxt        = in_pos_x;
              py_nxt        = in_pos_y;
              sel_valid_nxt = 1'b0;
              sel_slot_nxt  = '0;
              state_nxt     = ST_LOAD;
            end
            CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (sel_valid_r && ((CNTW+1)'(sel_slot_r) < (CNTW+1)'(count_r))) begin
                ctl.del_en     = 1'b1;
                count_nxt      = count_r - {{(CNTW-1){1'b0}}, 1'b1};
                sel_valid_nxt  = 1'b0;
                sel_slot_nxt   = '0;
                out_status_nxt = STAT_OK;
              end else begin
                out_status_nxt = STAT_NOT_FOUND;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_INVALID;
            end
          endcase
        end
      end
      ST_LOAD: begin
        ctl.hit_load = 1'b1;
        scan_idx_nxt = IDXW'(MAX_ENTRIES - 1);
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        // the top cell always holds the hit bit of slot scan_idx_r
        if (top_hit) begin
          sel_valid_nxt = 1'b1;
          sel_slot_nxt  = scan_idx_r;
          state_nxt     = ST_FIN;
        end else if (scan_idx_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          scan_idx_nxt  = scan_idx_r - {{(IDXW-1){1'b0}}, 1'b1};
          ctl.hit_shift = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sel_valid_r ? STAT_OK : STAT_NOT_FOUND;
          out_id_nxt     = '0;
          out_slot_nxt   = sel_valid_r ? SLOT_W'(sel_slot_r) : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sel_valid_r <= 1'b0;
      sel_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sel_valid_r <= sel_valid_nxt;
      sel_slot_r  <= sel_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_control_id = out_id_r;
  assign out_hit_slot   = out_slot_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_sel_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    sel_valid_r |-> ((CNTW+1)'(sel_slot_r) < (CNTW+1)'(count_r)))
    else $error("selection points past the last entry");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_ADD && count_r < CNTW'(MAX_ENTRIES))
      |=> count_r == $past(count_r) + {{(CNTW-1){1'b0}}, 1'b1})
    else $error("add did not grow the table");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_idx_r == '0) |=> state_r == ST_FIN)
    else $error("scan ran past the oldest slot");

  a_select_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_SELECT) |=> !sel_valid_r && state_r == ST_LOAD)
    else $error("select did not clear the old selection");
`endif

endmodule

`default_nettype wire

[rtl/zorht_cell.sv]
`default_nettype none

module zorht_cell #(
  parameter int COORD_BITS = 16,
  parameter int CNTW       = 9,
  parameter int IDXW       = 8,
  parameter int INDEX      = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  zorht_pkg::cell_ctl_t         ctl,
  input  wire  [CNTW-1:0]              count,
  input  wire  [IDXW-1:0]              sel_slot,
  input  wire  [COORD_BITS-1:0]        new_left,
  input  wire  [COORD_BITS-1:0]        new_top,
  input  wire  [COORD_BITS-1:0]        new_w,
  input  wire  [COORD_BITS-1:0]        new_h,
  input  wire  [COORD_BITS-1:0]        pt_x,
  input  wire  [COORD_BITS-1:0]        pt_y,
  input  wire  [COORD_BITS-1:0]        nb_left,
  input  wire  [COORD_BITS-1:0]        nb_top,
  input  wire  [COORD_BITS-1:0]        nb_w,
  input  wire  [COORD_BITS-1:0]        nb_h,
  input  wire                          hit_in,
  output logic [COORD_BITS-1:0]        left,
  output logic [COORD_BITS-1:0]        top,
  output logic [COORD_BITS-1:0]        w,
  output logic [COORD_BITS-1:0]        h,
  output logic                         hit_out
);

  import zorht_pkg::*;

  localparam logic [CNTW-1:0] IDX_C  = CNTW'(INDEX);
  localparam logic [CNTW-1:0] NEXT_C = CNTW'(INDEX + 1);
  localparam logic [IDXW-1:0] IDX_S  = IDXW'(INDEX);

  logic [COORD_BITS-1:0] left_r, top_r, w_r, h_r;
  logic                  hit_r;
  logic [COORD_BITS:0]   dx, dy;
  logic                  hit_now;
  logic                  take_new, take_nb;

  assign take_new = ctl.add_en && (count == IDX_C);
  assign take_nb  = ctl.del_en && (IDX_S >= sel_slot) && (NEXT_C < count);

  // offsets from the edges; non-negative and below the size means inside
  assign dx = {pt_x[COORD_BITS-1], pt_x} - {left_r[COORD_BITS-1], left_r};
  assign dy = {pt_y[COORD_BITS-1], pt_y} - {top_r[COORD_BITS-1], top_r};

  assign hit_now = (IDX_C < count)
                 && !dx[COORD_BITS] && (dx[COORD_BITS-1:0] < w_r)
                 && !dy[COORD_BITS] && (dy[COORD_BITS-1:0] < h_r);

  always_ff @(posedge clk) begin
    if (take_new) begin
      left_r <= new_left;
      top_r  <= new_top;
      w_r    <= new_w;
      h_r    <= new_h;
    end else if (take_nb) begin
      left_r <= nb_left;
      top_r  <= nb_top;
      w_r    <= nb_w;
      h_r    <= nb_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.hit_load) begin
      hit_r <= hit_now;
    end else if (ctl.hit_shift) begin
      hit_r <= hit_in;
    end
  end

  assign left    = left_r;
  assign top     = top_r;
  assign w       = w_r;
  assign h       = h_r;
  assign hit_out = hit_r;

endmodule

`default_nettype wire
